// File: design/csr_pkg.sv
`timescale 1ns / 1ps

package csr_pkg;

	localparam int VEC_DEPTH = 4096;
	localparam int VEC_AW = $clog2(VEC_DEPTH);

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_NZ = 2'd1;
	localparam logic [1:0] REQ_EMPTY = 2'd2;

	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] index;
		logic [63:0] value_bits;
		logic [19:0] row_number;
		logic        row_last;
	} req_t;

	typedef struct packed {
		logic [19:0] out_row;
		logic [63:0] row_sum_bits;
	} rsp_t;

	typedef struct packed {
		logic        is_nz;
		logic        last;
		logic [19:0] row;
	} tag_t;

	typedef struct packed {
		logic a1_nz;
		logic a2_nz;
	} add_busy_t;

	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		logic found;
		n = 7'd64;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 7'(63 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// File: design/csr_spmv_row_accumulator_core.sv
`timescale 1ns / 1ps

// Sparse matrix times dense vector accumulator for rows in CSR order.
// Input words arrive on req_valid/req_ready with the fields of req_t. A load
// word writes one binary64 entry into the vector memory and gives no result.
// A nonzero word reads its column entry, multiplies it by the widened binary32
// value and adds the product to the running row sum; the last nonzero of a row
// and every empty-row word give one result word on rsp_valid/rsp_ready.
// Loads and empty rows are taken one per cycle unless a stall holds the front.
// Nonzeros are paced by the running-sum loop: a nonzero waits while an earlier
// one is in either of the two stages of the binary64 adder before the running-sum
// register; the vector memory read and the five-stage multiplier are fully
// pipelined in front of it. Words pass the input register, the multiplier and
// adder stages and the output register, and results leave in accepted order.
// Reset clears the pipeline valids and sets the running sum to positive zero;
// the vector memory is not cleared and must be loaded before use.
// When the receiver holds rsp_ready low the result stays in the output
// register, the back end holds, and req_ready drops once the front fills.

module csr_spmv_row_accumulator_core import csr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic f_en, b_en, issue, acc, is_load, is_nz, is_empty, idx_ok;
	logic [63:0] rdata, b_in;

	logic r_v_s1, r_ok_s1;
	tag_t r_tag_s1;
	logic [31:0] r_a_s1;

	logic m_v, a_v;
	tag_t m_tag, a_tag;
	logic [63:0] m_p, a_res;
	add_busy_t busy;

	logic out_v_q;
	logic [19:0] out_row_q;
	logic [63:0] out_sum_q, running_sum_q;

	assign is_load = (req.req_type == REQ_LOAD);
	assign is_nz = (req.req_type == REQ_NZ);
	assign is_empty = (req.req_type == REQ_EMPTY);
	assign idx_ok = (int'(req.index) < VEC_DEPTH);

	assign b_en = !out_v_q || rsp_ready;
	assign issue = m_v && b_en && !(m_tag.is_nz && (busy.a1_nz || busy.a2_nz));
	assign f_en = !m_v || issue;
	assign req_ready = f_en;
	assign acc = req_valid && f_en;

	csr_vec_ram #(
		.DEPTH(VEC_DEPTH),
		.WIDTH(64)
	) u_ram (
		.clk(clk),
		.en(acc && (is_nz || (is_load && idx_ok))),
		.we(is_load),
		.addr(req.index[VEC_AW-1:0]),
		.wdata(req.value_bits),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_v_s1 <= 1'b0;
		end else if (f_en) begin
			r_v_s1 <= acc && (is_nz || is_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (f_en) begin
			r_tag_s1.is_nz <= is_nz;
			r_tag_s1.last <= req.row_last;
			r_tag_s1.row <= req.row_number;
			r_a_s1 <= req.value_bits[31:0];
			r_ok_s1 <= idx_ok;
		end
	end

	assign b_in = r_ok_s1 ? rdata : 64'd0;

	csr_fmul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.en(f_en),
		.in_v(r_v_s1),
		.in_tag(r_tag_s1),
		.a(r_a_s1),
		.b(b_in),
		.out_v(m_v),
		.out_tag(m_tag),
		.p(m_p)
	);

	csr_fadd u_add (
		.clk(clk),
		.arst_n(arst_n),
		.en(b_en),
		.in_v(issue),
		.in_tag(m_tag),
		.x(running_sum_q),
		.y(m_p),
		.out_v(a_v),
		.out_tag(a_tag),
		.sum(a_res),
		.busy(busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			running_sum_q <= 64'd0;
		end else begin
			if (b_en) begin
				out_v_q <= a_v && (!a_tag.is_nz || a_tag.last);
			end
			if (b_en && a_v && a_tag.is_nz) begin
				running_sum_q <= a_tag.last ? 64'd0 : a_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_en) begin
			out_row_q <= a_tag.row;
			out_sum_q <= a_tag.is_nz ? a_res : 64'd0;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp.out_row = out_row_q;
	assign rsp.row_sum_bits = out_sum_q;

endmodule

// File: design/csr_vec_ram.sv
`timescale 1ns / 1ps

module csr_vec_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: design/csr_fmul.sv
`timescale 1ns / 1ps

module csr_fmul import csr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  tag_t        in_tag,
	input  logic [31:0] a,
	input  logic [63:0] b,
	output logic        out_v,
	output tag_t        out_tag,
	output logic [63:0] p
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic r_nan, r_inf, r_zero;
	logic [6:0] na, nb;

	logic sgn_s1, nan_s1, inf_s1, zero_s1, suba_s1, subb_s1;
	logic [22:0] fa_s1;
	logic [51:0] fb_s1;
	logic [7:0] ea_s1;
	logic [10:0] eb_s1;
	logic [4:0] na_s1;
	logic [5:0] nb_s1;

	logic signed [12:0] e_a, e_b;
	logic [23:0] ma;
	logic [52:0] mb;
	logic sgn_s2, nan_s2, inf_s2, zero_s2;
	logic [23:0] ma_s2;
	logic [52:0] mb_s2;
	logic signed [12:0] e_s2;

	logic sgn_s3, nan_s3, inf_s3, zero_s3;
	logic [50:0] pplo_s3;
	logic [49:0] pphi_s3;
	logic signed [12:0] e_s3;

	logic [76:0] prod, pn;
	logic signed [12:0] biased, shv;
	logic sgn_s4, nan_s4, inf_s4, zero_s4, ovf_s4;
	logic [76:0] pn_s4;
	logic [10:0] expf_s4;
	logic [6:0] sh_s4;

	logic [156:0] ext;
	logic [76:0] keep;
	logic [51:0] frac;
	logic g, st, inc;
	logic [62:0] mag;
	logic [63:0] res, p_s5;

	always_comb begin
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
		b_zero = (b[62:0] == 63'd0);
		r_nan = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
		r_inf = !r_nan && (a_inf || b_inf);
		r_zero = !r_nan && !r_inf && (a_zero || b_zero);
		na = lzc64({1'b0, a[22:0], 40'hFF_FFFF_FFFF});
		nb = lzc64({1'b0, b[51:0], 11'h7FF});
	end

	always_comb begin
		ma = suba_s1 ? 24'({1'b0, fa_s1} << na_s1) : {1'b1, fa_s1};
		mb = subb_s1 ? 53'({1'b0, fb_s1} << nb_s1) : {1'b1, fb_s1};
		e_a = suba_s1 ? (-13'sd126 - $signed({8'b0, na_s1}))
			: ($signed({5'b0, ea_s1}) - 13'sd127);
		e_b = subb_s1 ? (-13'sd1022 - $signed({7'b0, nb_s1}))
			: ($signed({2'b0, eb_s1}) - 13'sd1023);
	end

	always_comb begin
		prod = {pphi_s3, 27'b0} + {26'b0, pplo_s3};
		pn = prod[76] ? prod : {prod[75:0], 1'b0};
		biased = e_s3 + 13'sd1023 + $signed({12'b0, prod[76]});
		shv = 13'sd1 - biased;
	end

	always_comb begin
		ext = {pn_s4, 80'b0} >> sh_s4;
		keep = ext[156:80];
		frac = keep[75:24];
		g = keep[23];
		st = (|keep[22:0]) || (|ext[79:0]);
		inc = g && (st || frac[0]);
		mag = {expf_s4, frac} + {62'b0, inc};
		if (nan_s4) begin
			res = CANON_NAN;
		end else if (inf_s4 || ovf_s4) begin
			res = {sgn_s4, 11'h7FF, 52'b0};
		end else if (zero_s4) begin
			res = {sgn_s4, 63'b0};
		end else begin
			res = {sgn_s4, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			sgn_s1 <= a[31] ^ b[63];
			nan_s1 <= r_nan;
			inf_s1 <= r_inf;
			zero_s1 <= r_zero;
			suba_s1 <= (a[30:23] == 8'd0);
			subb_s1 <= (b[62:52] == 11'd0);
			fa_s1 <= a[22:0];
			fb_s1 <= b[51:0];
			ea_s1 <= a[30:23];
			eb_s1 <= b[62:52];
			na_s1 <= na[4:0];
			nb_s1 <= nb[5:0];

			tag_s2 <= tag_s1;
			sgn_s2 <= sgn_s1;
			nan_s2 <= nan_s1;
			inf_s2 <= inf_s1;
			zero_s2 <= zero_s1;
			ma_s2 <= ma;
			mb_s2 <= mb;
			e_s2 <= e_a + e_b;

			tag_s3 <= tag_s2;
			sgn_s3 <= sgn_s2;
			nan_s3 <= nan_s2;
			inf_s3 <= inf_s2;
			zero_s3 <= zero_s2;
			pplo_s3 <= ma_s2 * mb_s2[26:0];
			pphi_s3 <= ma_s2 * mb_s2[52:27];
			e_s3 <= e_s2;

			tag_s4 <= tag_s3;
			sgn_s4 <= sgn_s3;
			nan_s4 <= nan_s3;
			inf_s4 <= inf_s3;
			zero_s4 <= zero_s3;
			pn_s4 <= pn;
			ovf_s4 <= (biased >= 13'sd2047);
			expf_s4 <= (biased < 13'sd1) ? 11'd0 : biased[10:0];
			sh_s4 <= (biased >= 13'sd1) ? 7'd0 : ((shv > 13'sd100) ? 7'd100 : shv[6:0]);

			tag_s5 <= tag_s4;
			p_s5 <= res;
		end
	end

	assign out_v = v_s5;
	assign out_tag = tag_s5;
	assign p = p_s5;

endmodule

// File: design/csr_fadd.sv
`timescale 1ns / 1ps

module csr_fadd import csr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  tag_t        in_tag,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic        out_v,
	output tag_t        out_tag,
	output logic [63:0] sum,
	output add_busy_t   busy
);

	logic x_nan, x_inf, y_nan, y_inf, x_big;
	logic [63:0] bg, sm;
	logic [10:0] eb_e, es_e, d;
	logic [6:0] dc;
	logic [52:0] m_b, m_s;
	logic [111:0] ext;
	logic [55:0] aligned;

	logic v_s1, v_s2;
	tag_t tag_s1, tag_s2;
	logic sgn_s1, sub_s1, nan_s1, inf_s1, isgn_s1, zsgn_s1;
	logic [11:0] e_s1;
	logic [55:0] mb_s1, ms_s1;

	logic [56:0] s57;
	logic sgn_s2, nan_s2, inf_s2, isgn_s2, zsgn_s2;
	logic [11:0] e_s2;
	logic [56:0] sum_s2;
	logic [6:0] lz_s2;

	logic [11:0] lim, lz12, sh, ef;
	logic [55:0] m;
	logic [10:0] expf;
	logic [51:0] frac;
	logic inc;
	logic [62:0] mag;

	always_comb begin
		x_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
		x_inf = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
		y_nan = (y[62:52] == 11'h7FF) && (y[51:0] != 52'd0);
		y_inf = (y[62:52] == 11'h7FF) && (y[51:0] == 52'd0);
		x_big = (x[62:0] >= y[62:0]);
		bg = x_big ? x : y;
		sm = x_big ? y : x;
		eb_e = (bg[62:52] == 11'd0) ? 11'd1 : bg[62:52];
		es_e = (sm[62:52] == 11'd0) ? 11'd1 : sm[62:52];
		m_b = {bg[62:52] != 11'd0, bg[51:0]};
		m_s = {sm[62:52] != 11'd0, sm[51:0]};
		d = eb_e - es_e;
		dc = (d > 11'd57) ? 7'd57 : d[6:0];
		ext = {m_s, 3'b0, 56'b0} >> dc;
		aligned = {ext[111:57], ext[56] | (|ext[55:0])};
	end

	always_comb begin
		s57 = sub_s1 ? ({1'b0, mb_s1} - {1'b0, ms_s1}) : ({1'b0, mb_s1} + {1'b0, ms_s1});
	end

	always_comb begin
		lim = e_s2 - 12'd1;
		lz12 = {5'b0, lz_s2};
		sh = (lz12 < lim) ? lz12 : lim;
		if (sum_s2[56]) begin
			m = {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			ef = e_s2 + 12'd1;
		end else begin
			m = sum_s2[55:0] << sh[5:0];
			ef = e_s2 - sh;
		end
		expf = m[55] ? ef[10:0] : 11'd0;
		frac = m[54:3];
		inc = m[2] && (m[1] || m[0] || frac[0]);
		mag = {expf, frac} + {62'b0, inc};
		if (nan_s2) begin
			sum = CANON_NAN;
		end else if (inf_s2) begin
			sum = {isgn_s2, 11'h7FF, 52'b0};
		end else if (sum_s2 == 57'd0) begin
			sum = {zsgn_s2, 63'b0};
		end else if (ef >= 12'd2047) begin
			sum = {sgn_s2, 11'h7FF, 52'b0};
		end else begin
			sum = {sgn_s2, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			sgn_s1 <= bg[63];
			sub_s1 <= x[63] ^ y[63];
			nan_s1 <= x_nan || y_nan || (x_inf && y_inf && (x[63] != y[63]));
			inf_s1 <= x_inf || y_inf;
			isgn_s1 <= x_inf ? x[63] : y[63];
			zsgn_s1 <= x[63] & y[63];
			e_s1 <= {1'b0, eb_e};
			mb_s1 <= {m_b, 3'b0};
			ms_s1 <= aligned;

			tag_s2 <= tag_s1;
			sgn_s2 <= sgn_s1;
			nan_s2 <= nan_s1;
			inf_s2 <= inf_s1;
			isgn_s2 <= isgn_s1;
			zsgn_s2 <= zsgn_s1;
			e_s2 <= e_s1;
			sum_s2 <= s57;
			lz_s2 <= lzc64({s57[55:0], 8'hFF});
		end
	end

	assign out_v = v_s2;
	assign out_tag = tag_s2;
	assign busy.a1_nz = v_s1 && tag_s1.is_nz;
	assign busy.a2_nz = v_s2 && tag_s2.is_nz;

endmodule

// File: design/csr_checker.sv
`timescale 1ns / 1ps

module csr_checker import csr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("result word changed while stalled");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.row_sum_bits[62:52] == 11'h7FF) && (rsp.row_sum_bits[51:0] != 52'd0)
		|-> rsp.row_sum_bits == CANON_NAN)
		else $error("row sum is a non-canonical NaN");

	a_reset_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(arst_n, 1) || !$past(arst_n, 2) || !$past(arst_n, 3) || !$past(arst_n, 4)
		|| !$past(arst_n, 5) || !$past(arst_n, 6) || !$past(arst_n, 7)) |-> !rsp_valid)
		else $error("result word too soon after reset");

endmodule

bind csr_spmv_row_accumulator_core csr_checker u_chk (.*);
